[sv/rgb2hsv_pkg.sv]
// Shared widths and stage payload types for the RGB to HSV pixel pipeline.
`default_nettype none

package rgb2hsv_pkg;

    // Channel width and the width of the quotients (hue and saturation)
    localparam int CH_W      = 8;
    localparam int DIV_STEPS = CH_W;
    localparam int NUM_W     = 2 * CH_W;

    // One restoring-division lane: partial remainder and the dividend low
    // bits, which fill with quotient bits from the right as the steps go on.
    typedef struct packed {
        logic [CH_W-1:0] rem;
        logic [CH_W-1:0] lowq;
    } lane_t;

    // Payload that travels down the division stages
    typedef struct packed {
        lane_t           hue_lane;
        lane_t           sat_lane;
        logic [CH_W-1:0] delta;
        logic [CH_W-1:0] mx;
        logic            gray;
    } div_stage_t;

endpackage

`default_nettype wire

[sv/rgb2hsv_ifs.sv]
// Valid/ready channel interfaces for RGB input items and HSV result items.
`default_nettype none

interface rgb2hsv_rgb_if;
    logic                        valid;
    logic                        ready;
    logic [rgb2hsv_pkg::CH_W-1:0] red;
    logic [rgb2hsv_pkg::CH_W-1:0] green;
    logic [rgb2hsv_pkg::CH_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgb2hsv_hsv_if;
    logic                        valid;
    logic                        ready;
    logic [rgb2hsv_pkg::CH_W-1:0] hue;
    logic [rgb2hsv_pkg::CH_W-1:0] saturation;
    logic [rgb2hsv_pkg::CH_W-1:0] brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

`default_nettype wire

[sv/rgb2hsv_prep.sv]
// First pipeline stage: max, min, delta, hue sector and the two dividends.
`default_nettype none

module rgb2hsv_prep (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          up_valid,
    output logic                               up_ready,
    input  wire logic [rgb2hsv_pkg::CH_W-1:0]  red,
    input  wire logic [rgb2hsv_pkg::CH_W-1:0]  green,
    input  wire logic [rgb2hsv_pkg::CH_W-1:0]  blue,
    output logic                               dn_valid,
    input  wire logic                          dn_ready,
    output rgb2hsv_pkg::div_stage_t            dn_data
);
    import rgb2hsv_pkg::*;

    localparam logic [CH_W-1:0] OFF_RED_WRAP = CH_W'(180);
    localparam logic [CH_W-1:0] OFF_GREEN    = CH_W'(60);
    localparam logic [CH_W-1:0] OFF_BLUE     = CH_W'(120);
    localparam int              PROD_W       = NUM_W + 2;

    logic                     valid_reg;
    div_stage_t               data_reg;
    div_stage_t               data_next;

    logic [CH_W-1:0]          mx;
    logic [CH_W-1:0]          mn;
    logic [CH_W-1:0]          delta;
    logic [CH_W-1:0]          offset;
    logic signed [CH_W+1:0]   n_s;
    logic [NUM_W-1:0]         off_prod;
    logic signed [PROD_W-1:0] num_s;
    logic [NUM_W-1:0]         sat_num;

    // Pick max, min and the hue sector (ties go to red, then green)
    always_comb
    begin
        mx = (red > green) ? red : green;
        if (blue > mx)
        begin
            mx = blue;
        end
        mn = (red < green) ? red : green;
        if (blue < mn)
        begin
            mn = blue;
        end
        delta = mx - mn;

        if (mx == red)
        begin
            n_s    = $signed({2'b00, green}) - $signed({2'b00, blue});
            offset = n_s[CH_W+1] ? OFF_RED_WRAP : '0;
        end
        else if (mx == green)
        begin
            n_s    = $signed({2'b00, blue}) - $signed({2'b00, red});
            offset = OFF_GREEN;
        end
        else
        begin
            n_s    = $signed({2'b00, red}) - $signed({2'b00, green});
            offset = OFF_BLUE;
        end

        // Hue dividend 30*n + offset*delta is never negative and fits NUM_W
        off_prod = NUM_W'(offset) * NUM_W'(delta);
        num_s    = PROD_W'(n_s) * PROD_W'(30) + $signed({2'b00, off_prod});
        // Saturation dividend 255*delta
        sat_num  = {delta, {CH_W{1'b0}}} - NUM_W'(delta);

        data_next.hue_lane.rem  = num_s[NUM_W-1:CH_W];
        data_next.hue_lane.lowq = num_s[CH_W-1:0];
        data_next.sat_lane.rem  = sat_num[NUM_W-1:CH_W];
        data_next.sat_lane.lowq = sat_num[CH_W-1:0];
        data_next.delta         = delta;
        data_next.mx            = mx;
        data_next.gray          = (delta == '0);
    end

    assign up_ready = !valid_reg || dn_ready;

    // Advance the stage whenever it is empty or the next one takes the item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    // Load the payload; no reset needed
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

`default_nettype wire

[sv/rgb2hsv_div_step.sv]
// One restoring-division stage: retires one quotient bit in both lanes.
`default_nettype none

module rgb2hsv_div_step (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                up_valid,
    output logic                     up_ready,
    input  rgb2hsv_pkg::div_stage_t  up_data,
    output logic                     dn_valid,
    input  wire logic                dn_ready,
    output rgb2hsv_pkg::div_stage_t  dn_data
);
    import rgb2hsv_pkg::*;

    logic       valid_reg;
    div_stage_t data_reg;
    div_stage_t data_next;

    // Shift in the next dividend bit, subtract the divisor when it fits
    function automatic lane_t lane_step(lane_t cur, logic [CH_W-1:0] divisor);
        logic [CH_W:0] trial;
        logic          take;
        lane_t         res;
        trial = {cur.rem, cur.lowq[CH_W-1]};
        take  = (trial >= {1'b0, divisor});
        if (take)
        begin
            trial = trial - {1'b0, divisor};
        end
        res.rem  = trial[CH_W-1:0];
        res.lowq = {cur.lowq[CH_W-2:0], take};
        return res;
    endfunction

    always_comb
    begin
        data_next          = up_data;
        data_next.hue_lane = lane_step(up_data.hue_lane, up_data.delta);
        data_next.sat_lane = lane_step(up_data.sat_lane, up_data.mx);
    end

    assign up_ready = !valid_reg || dn_ready;

    // Advance when empty or when the next stage takes the item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

`default_nettype wire

[sv/rgb_to_hsv_pixel.sv]
// Top level of the RGB to HSV pixel converter (8-bit HSV, hue in degrees halved).
// Usage:
//   rgb  - input channel; one item is one 8-bit RGB pixel, taken when
//          valid and ready are both high.
//   hsv  - result channel; one item per pixel, in order: hue 0..179,
//          saturation 0..255, brightness = max(red, green, blue).
// Path: ten registers sit between rgb and hsv, and the accepting edge loads
//   the first: one stage for max/min and the dividends, eight
//   restoring-division stages that each retire one quotient bit of hue and
//   saturation, one output register.
// Throughput: one pixel per clock while hsv.ready is high; every stage holds its own valid bit.
// Stall: when hsv.ready is low the result holds and items pile up behind
//   it; each stage stays open while it or a later stage has a bubble, so
//   rgb.ready drops only once the whole pipeline is full. Nothing is lost
//   or repeated.
// Reset: rst_n clears all valid bits; the payload registers are not reset,
//   and the block is ready for an item in the first cycle after reset.
`default_nettype none

module rgb_to_hsv_pixel (
    input  wire logic     clk,
    input  wire logic     rst_n,
    rgb2hsv_rgb_if.sink   rgb,
    rgb2hsv_hsv_if.source hsv
);
    import rgb2hsv_pkg::*;

    logic       st_valid [0:DIV_STEPS];
    logic       st_ready [0:DIV_STEPS];
    div_stage_t st_data  [0:DIV_STEPS];

    logic            out_valid_reg;
    logic [CH_W-1:0] hue_reg;
    logic [CH_W-1:0] sat_reg;
    logic [CH_W-1:0] bri_reg;
    logic            out_ready;

    rgb2hsv_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (rgb.valid),
        .up_ready (rgb.ready),
        .red      (rgb.red),
        .green    (rgb.green),
        .blue     (rgb.blue),
        .dn_valid (st_valid[0]),
        .dn_ready (st_ready[0]),
        .dn_data  (st_data[0])
    );

    // Chain of division stages, one quotient bit each
    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        rgb2hsv_div_step u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (st_valid[k]),
            .up_ready (st_ready[k]),
            .up_data  (st_data[k]),
            .dn_valid (st_valid[k+1]),
            .dn_ready (st_ready[k+1]),
            .dn_data  (st_data[k+1])
        );
    end

    assign out_ready               = !out_valid_reg || hsv.ready;
    assign st_ready[DIV_STEPS]     = out_ready;

    // Hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= st_valid[DIV_STEPS];
        end
    end

    // Drop the quotients to zero for gray and black pixels
    always_ff @(posedge clk)
    begin
        if (out_ready && st_valid[DIV_STEPS])
        begin
            hue_reg <= st_data[DIV_STEPS].gray ? '0 : st_data[DIV_STEPS].hue_lane.lowq;
            sat_reg <= st_data[DIV_STEPS].gray ? '0 : st_data[DIV_STEPS].sat_lane.lowq;
            bri_reg <= st_data[DIV_STEPS].mx;
        end
    end

    assign hsv.valid      = out_valid_reg;
    assign hsv.hue        = hue_reg;
    assign hsv.saturation = sat_reg;
    assign hsv.brightness = bri_reg;

endmodule

`default_nettype wire

[sv/rgb2hsv_check.sv]
// Port-level checker for the RGB to HSV converter, bound to the top level.
`default_nettype none

module rgb2hsv_check (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          hsv_valid,
    input wire logic                          hsv_ready,
    input wire logic [rgb2hsv_pkg::CH_W-1:0]  hue,
    input wire logic [rgb2hsv_pkg::CH_W-1:0]  saturation,
    input wire logic [rgb2hsv_pkg::CH_W-1:0]  brightness
);
    import rgb2hsv_pkg::*;

    localparam logic [CH_W-1:0] HUE_MAX = CH_W'(179);

    // A stalled result stays valid
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && !hsv_ready |=> hsv_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && !hsv_ready |=>
            $stable(hue) && $stable(saturation) && $stable(brightness))
        else $error("result payload changed while stalled");

    // Hue stays within its range in degrees halved
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid |-> hue <= HUE_MAX)
        else $error("hue out of range");

    // Black pixel gives zero hue and saturation
    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && brightness == '0 |-> saturation == '0 && hue == '0)
        else $error("black pixel with nonzero hue or saturation");

    // Zero saturation only for gray pixels, which have zero hue
    a_gray: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && saturation == '0 |-> hue == '0)
        else $error("unsaturated pixel with nonzero hue");

endmodule

bind rgb_to_hsv_pixel rgb2hsv_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .hsv_valid  (hsv.valid),
    .hsv_ready  (hsv.ready),
    .hue        (hsv.hue),
    .saturation (hsv.saturation),
    .brightness (hsv.brightness)
);

`default_nettype wire

[dv/tb_rgb_to_hsv_pixel.sv]
// Testbench for rgb_to_hsv_pixel: random and directed pixels checked against a predictor.
`timescale 1ns / 1ps

module tb_rgb_to_hsv_pixel;

    import rgb2hsv_pkg::*;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [CH_W-1:0] hue;
        logic [CH_W-1:0] saturation;
        logic [CH_W-1:0] brightness;
    } hsv_t;

    // Expected HSV per accepted pixel, checked in order
    class hsv_scoreboard;
        hsv_t pending_hsv[$];
        int   errors = 0;

        // Exact integer conversion, hue in degrees halved
        function hsv_t hsv_of(rgb_t px);
            int   r, g, b;
            int   mx, mn, delta, n, num, quot;
            hsv_t res;
            r = int'(px.red);
            g = int'(px.green);
            b = int'(px.blue);
            mx = (r > g) ? r : g;
            mx = (mx > b) ? mx : b;
            mn = (r < g) ? r : g;
            mn = (mn < b) ? mn : b;
            delta = mx - mn;
            res.brightness = mx[CH_W-1:0];
            res.hue = '0;
            res.saturation = '0;
            if (mx != 0 && delta != 0)
            begin
                quot = (255 * delta) / mx;
                res.saturation = quot[CH_W-1:0];
                // Sector follows the first channel that holds the maximum
                if (mx == r)
                begin
                    n = g - b;
                    num = 30 * n;
                    if (n < 0)
                        num = num + 180 * delta;
                end
                else if (mx == g)
                begin
                    n = b - r;
                    num = 30 * n + 60 * delta;
                end
                else
                begin
                    n = r - g;
                    num = 30 * n + 120 * delta;
                end
                if (num < 0)
                    num = 0;
                quot = num / delta;
                if (quot > 179)
                    quot = 179;
                res.hue = quot[CH_W-1:0];
            end
            return res;
        endfunction

        function void note_pixel(rgb_t px);
            pending_hsv.push_back(hsv_of(px));
        endfunction

        function void check_result(hsv_t got);
            hsv_t want;
            if (pending_hsv.size() == 0)
            begin
                $error("result with no pixel pending: hue %0d saturation %0d brightness %0d",
                       got.hue, got.saturation, got.brightness);
                errors++;
                return;
            end
            want = pending_hsv.pop_front();
            if (got.hue !== want.hue)
            begin
                $error("hue mismatch: expected %0d, got %0d", want.hue, got.hue);
                errors++;
            end
            if (got.saturation !== want.saturation)
            begin
                $error("saturation mismatch: expected %0d, got %0d",
                       want.saturation, got.saturation);
                errors++;
            end
            if (got.brightness !== want.brightness)
            begin
                $error("brightness mismatch: expected %0d, got %0d",
                       want.brightness, got.brightness);
                errors++;
            end
        endfunction
    endclass

    localparam int RANDOM_PIXELS = 2000;
    localparam int PHASES        = 4;

    logic clk = 1'b0;
    logic rst_n;
    int   send_idle_pct;
    int   stall_pct;

    hsv_scoreboard sb = new();

    rgb2hsv_rgb_if rgb_ch ();
    rgb2hsv_hsv_if hsv_ch ();

    rgb_to_hsv_pixel dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rgb   (rgb_ch),
        .hsv   (hsv_ch)
    );

    always #10 clk = ~clk;

    // Stall the result channel at random
    always @(posedge clk)
    begin
        hsv_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Note each accepted pixel
    always @(posedge clk)
    begin
        if (rst_n && rgb_ch.valid && rgb_ch.ready)
            sb.note_pixel('{red: rgb_ch.red, green: rgb_ch.green, blue: rgb_ch.blue});
    end

    // Check each accepted result
    always @(posedge clk)
    begin
        if (rst_n && hsv_ch.valid && hsv_ch.ready)
            sb.check_result('{hue: hsv_ch.hue, saturation: hsv_ch.saturation,
                              brightness: hsv_ch.brightness});
    end

    // Offer one pixel, idling first at random, and hold it until taken
    task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                              input logic [CH_W-1:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            rgb_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rgb_ch.valid <= 1'b1;
        rgb_ch.red   <= r;
        rgb_ch.green <= g;
        rgb_ch.blue  <= b;
        do
            @(posedge clk);
        while (!rgb_ch.ready);
    endtask

    // Random pixel, weighted toward ties, grays and edge values
    task automatic send_random_pixel();
        int          mode;
        logic [CH_W-1:0] r, g, b, v;
        mode = $urandom_range(0, 99);
        r = CH_W'($urandom_range(0, 255));
        g = CH_W'($urandom_range(0, 255));
        b = CH_W'($urandom_range(0, 255));
        v = CH_W'($urandom_range(0, 255));
        if (mode < 55)
            ;
        else if (mode < 65)
        begin
            g = r;
            b = r;
        end
        else if (mode < 80)
        begin
            // two channels share the maximum
            case ($urandom_range(0, 2))
                0: begin r = v; g = v; b = CH_W'($urandom_range(0, v)); end
                1: begin g = v; b = v; r = CH_W'($urandom_range(0, v)); end
                default: begin r = v; b = v; g = CH_W'($urandom_range(0, v)); end
            endcase
        end
        else if (mode < 90)
        begin
            r = CH_W'($urandom_range(0, 3));
            g = CH_W'($urandom_range(0, 3));
            b = CH_W'($urandom_range(0, 3));
        end
        else
        begin
            // one channel at full scale, another at zero
            case ($urandom_range(0, 2))
                0: begin r = 8'hFF; b = 8'h00; end
                1: begin g = 8'hFF; r = 8'h00; end
                default: begin b = 8'hFF; g = 8'h00; end
            endcase
        end
        send_pixel(r, g, b);
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        rgb_ch.valid  <= 1'b0;
        rgb_ch.red    <= '0;
        rgb_ch.green  <= '0;
        rgb_ch.blue   <= '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pixels: black, white, grays, primaries, ties, hue wrap
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd1,   8'd1,   8'd1);
        send_pixel(8'd255, 8'd0,   8'd0);
        send_pixel(8'd0,   8'd255, 8'd0);
        send_pixel(8'd0,   8'd0,   8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd255, 8'd0,   8'd255);
        send_pixel(8'd1,   8'd0,   8'd0);
        send_pixel(8'd0,   8'd1,   8'd0);
        send_pixel(8'd0,   8'd0,   8'd1);
        send_pixel(8'd255, 8'd0,   8'd1);
        send_pixel(8'd255, 8'd1,   8'd0);
        send_pixel(8'd255, 8'd254, 8'd255);
        send_pixel(8'd1,   8'd255, 8'd254);
        send_pixel(8'd254, 8'd1,   8'd255);
        send_pixel(8'd255, 8'd254, 8'd253);
        send_pixel(8'd10,  8'd20,  8'd30);
        send_pixel(8'd200, 8'd100, 8'd50);
        send_pixel(8'd170, 8'd85,  8'd0);
        send_pixel(8'd85,  8'd170, 8'd255);

        // Random pixels over phases of input idling and output stalls
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 83; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 83; end
                default: begin send_idle_pct = 11; stall_pct = 11; end
            endcase
            for (int i = 0; i < RANDOM_PIXELS / PHASES; i++)
                send_random_pixel();
        end
        rgb_ch.valid <= 1'b0;

        // Drain the pipeline, then let it settle
        while (sb.pending_hsv.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (sb.errors == 0 && sb.pending_hsv.size() == 0)
            $display("tb_rgb_to_hsv_pixel: clean");
        else
            $display("tb_rgb_to_hsv_pixel: errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("tb_rgb_to_hsv_pixel: errors");
        $finish;
    end

endmodule
